/* rtl/interval_overlap_classifier_core_macros.svh */
// Assertion helpers for the interval overlap classifier.
`ifndef INTERVAL_OVERLAP_CLASSIFIER_CORE_MACROS_SVH
`define INTERVAL_OVERLAP_CLASSIFIER_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define IOC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define IOC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ioc_pkg.sv */
package ioc_pkg;

  localparam int CoordW = 31;
  localparam int ClassW = 2;
  localparam int KindW  = 2;
  localparam int RelW   = 3;
  localparam int IndexW = 10;
  localparam int PctW   = 14;
  localparam int ProdW  = CoordW + PctW;

  localparam logic [PctW-1:0] PctFull = 14'd10000;

  localparam logic [KindW-1:0] KIND_CLEAR  = 2'd0;
  localparam logic [KindW-1:0] KIND_APPEND = 2'd1;
  localparam logic [KindW-1:0] KIND_QUERY  = 2'd2;

  localparam logic [RelW-1:0] REL_CONTAINED = 3'd0;
  localparam logic [RelW-1:0] REL_CONTAINS  = 3'd1;
  localparam logic [RelW-1:0] REL_BEGINS    = 3'd2;
  localparam logic [RelW-1:0] REL_ENDS      = 3'd3;
  localparam logic [RelW-1:0] REL_NONE      = 3'd4;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [CoordW-1:0] span_start;
    logic [CoordW-1:0] span_stop;
    logic [ClassW-1:0] span_class;
  } in_item_t;

  typedef struct packed {
    logic [RelW-1:0]   relation;
    logic [ClassW-1:0] ref_class;
    logic [IndexW-1:0] ref_index;
    logic [CoordW-1:0] ref_start;
    logic [CoordW-1:0] ref_stop;
    logic [CoordW-1:0] overlap_len;
    logic [PctW-1:0]   query_pct;
    logic [PctW-1:0]   ref_pct;
    logic              last;
    logic              overflow;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [CoordW-1:0] part;
    logic [CoordW-1:0] whole;
  } div_req_t;

  function automatic logic [CoordW-1:0] span_len(input logic [CoordW-1:0] a,
                                                 input logic [CoordW-1:0] b);
    return (b >= a) ? (b - a) : '0;
  endfunction

endpackage

/* rtl/interval_overlap_classifier_core.sv */
// Interval overlap classifier.
// Input channel (in_valid/in_stall/in_item): kind CLEAR empties the reference
// table, APPEND adds one reference interval (dropped when the table is full),
// QUERY classifies an interval against the table. Output channel
// (out_valid/out_stall/out_item) carries the results of a query, the final one
// flagged by last. Clear and append produce no result.
// Clear and append leave the block idle, ready for the next item. A query
// reads the table from the table RAM one entry per cycle between hits, first
// in a containment pass and then, if no entry contains it, in an overlap pass;
// each result then goes through the pair of bit-serial percent dividers.
// The overlap pass restarts after each hit at the next entry.
// in_stall stays high while a query is in progress; a finished result sits in
// the output register, so the next item is taken even while the receiver
// stalls. A stalled output holds the block only when another result is ready.
// Reset empties the table (its RAM contents are not cleared) and drops any
// result in flight.
module interval_overlap_classifier_core import ioc_pkg::*; #(
  parameter int TABLE_DEPTH = 1024,
  parameter int MAX_HITS    = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

`include "interval_overlap_classifier_core_macros.svh"

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int CW    = $clog2(TABLE_DEPTH + 1);
  localparam int HW    = $clog2(MAX_HITS + 1);
  localparam int WordW = 2 * CoordW + ClassW;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN1, S_SCAN2, S_DIV_GO, S_DIV_WAIT, S_PUSH, S_FIN
  } state_t;

  state_t            state;
  logic [CW-1:0]     cnt;
  logic [CW-1:0]     addr;
  logic              rd_vld;
  logic [AW-1:0]     rd_idx;
  logic [CoordW-1:0] qb;
  logic [CoordW-1:0] qe;
  logic [CoordW-1:0] qlen;
  out_item_t         cur;
  out_item_t         pend;
  logic              have_pend;
  logic [HW-1:0]     nhits;
  logic              ovf;
  logic              final_hit;

  logic              we;
  logic [WordW-1:0]  rdata;
  logic [CoordW-1:0] rs, re;
  logic [ClassW-1:0] rc;
  logic              issue, out_free, accept;
  logic              c_in, c_contains, c_begins, c_ends, hit2;
  logic [RelW-1:0]   rel2;
  logic [CoordW-1:0] ovl2;
  div_req_t          qreq, rreq;
  logic              qbusy, rbusy;
  logic [PctW-1:0]   qpct, rpct;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign we       = accept && (in_item.kind == KIND_APPEND) && (cnt < CW'(TABLE_DEPTH));
  assign out_free = !out_valid || !out_stall;
  assign issue    = (addr < cnt);

  ioc_ram #(.Width(WordW), .Depth(TABLE_DEPTH)) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(cnt[AW-1:0]),
    .wdata({in_item.span_start, in_item.span_stop, in_item.span_class}),
    .raddr(addr[AW-1:0]),
    .rdata(rdata)
  );

  assign {rs, re, rc} = rdata;

  assign c_in       = (rs <= qb) && (qe <= re);
  assign c_contains = (qb <= rs) && (re <= qe);
  assign c_begins   = (qb <= re) && (re <= qe);
  assign c_ends     = (qb <= rs) && (rs <= qe);
  assign hit2       = c_contains || c_begins || c_ends;

  always_comb begin
    if (c_contains) begin
      rel2 = REL_CONTAINS;
      ovl2 = span_len(rs, re);
    end else if (c_begins) begin
      rel2 = REL_BEGINS;
      ovl2 = re - qb;
    end else begin
      rel2 = REL_ENDS;
      ovl2 = qe - rs;
    end
  end

  assign qreq = '{start: (state == S_DIV_GO), part: cur.overlap_len, whole: qlen};
  assign rreq = '{start: (state == S_DIV_GO), part: cur.overlap_len,
                  whole: span_len(cur.ref_start, cur.ref_stop)};

  ioc_pct_div u_qdiv (.clk(clk), .rst(rst), .req(qreq), .busy(qbusy), .quot(qpct));
  ioc_pct_div u_rdiv (.clk(clk), .rst(rst), .req(rreq), .busy(rbusy), .quot(rpct));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      rd_vld    <= 1'b0;
      have_pend <= 1'b0;
      out_valid <= 1'b0;
      nhits     <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            case (in_item.kind)
              KIND_CLEAR:  cnt <= '0;
              KIND_APPEND: begin
                if (cnt < CW'(TABLE_DEPTH)) begin
                  cnt <= cnt + 1'b1;
                end
              end
              KIND_QUERY: begin
                qb        <= in_item.span_start;
                qe        <= in_item.span_stop;
                qlen      <= span_len(in_item.span_start, in_item.span_stop);
                addr      <= '0;
                rd_vld    <= 1'b0;
                nhits     <= '0;
                have_pend <= 1'b0;
                ovf       <= 1'b0;
                final_hit <= 1'b0;
                state     <= S_SCAN1;
              end
              default: ;
            endcase
          end
        end
        S_SCAN1, S_SCAN2: begin
          rd_vld <= issue;
          rd_idx <= addr[AW-1:0];
          if (issue) begin
            addr <= addr + 1'b1;
          end
          if (state == S_SCAN1) begin
            if (rd_vld && c_in) begin
              cur       <= '{relation: REL_CONTAINED, ref_class: rc,
                             ref_index: IndexW'(rd_idx), ref_start: rs, ref_stop: re,
                             overlap_len: qlen, default: '0};
              final_hit <= 1'b1;
              rd_vld    <= 1'b0;
              state     <= S_DIV_GO;
            end else if (!rd_vld && !issue) begin
              addr  <= '0;
              state <= S_SCAN2;
            end
          end else begin
            if (rd_vld && hit2) begin
              rd_vld <= 1'b0;
              if (nhits == HW'(MAX_HITS)) begin
                ovf   <= 1'b1;
                state <= S_FIN;
              end else begin
                cur   <= '{relation: rel2, ref_class: rc, ref_index: IndexW'(rd_idx),
                           ref_start: rs, ref_stop: re, overlap_len: ovl2,
                           default: '0};
                // resume the scan just past this entry
                addr  <= CW'(rd_idx) + 1'b1;
                state <= S_DIV_GO;
              end
            end else if (!rd_vld && !issue) begin
              if (!have_pend) begin
                pend <= '{relation: REL_NONE, default: '0};
              end
              state <= S_FIN;
            end
          end
        end
        S_DIV_GO: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (!qbusy && !rbusy) begin
            cur.query_pct <= qpct;
            cur.ref_pct   <= rpct;
            state         <= S_PUSH;
          end
        end
        S_PUSH: begin
          // the held result goes out only once we know another one follows it
          if (!have_pend || out_free) begin
            if (have_pend) begin
              out_item  <= pend;
              out_valid <= 1'b1;
            end
            pend      <= cur;
            have_pend <= 1'b1;
            nhits     <= nhits + 1'b1;
            state     <= final_hit ? S_FIN : S_SCAN2;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_item          <= pend;
            out_item.last     <= 1'b1;
            out_item.overflow <= ovf;
            out_valid         <= 1'b1;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `IOC_ASSERT_NOW(a_hits_bound, 1'b1, nhits <= HW'(MAX_HITS), "hit count beyond limit")
  `IOC_ASSERT_NOW(a_ovf_last, out_valid && out_item.overflow, out_item.last,
                  "overflow on a non-final result")
  `IOC_ASSERT_NOW(a_none_last, out_valid && out_item.relation == REL_NONE, out_item.last,
                  "no-overlap result not final")
  `IOC_ASSERT_NEXT(a_query_busy, accept && in_item.kind == KIND_QUERY, in_stall,
                   "query accepted without entering scan")

endmodule

/* rtl/ioc_ram.sv */
module ioc_ram #(
  parameter int Width = 64,
  parameter int Depth = 1024,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/ioc_pct_div.sv */
module ioc_pct_div import ioc_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  div_req_t        req,
  output logic            busy,
  output logic [PctW-1:0] quot
);

  logic [ProdW-1:0]  prod;
  logic [CoordW-1:0] den;
  logic [CoordW-1:0] rem;
  logic [PctW-1:0]   sh;
  logic [PctW-1:0]   q;
  logic [3:0]        cnt;
  logic              zero_den;
  logic              sat;
  logic [CoordW:0]   trial;

  assign trial = {rem, sh[PctW-1]};

  // part*10000 < whole*2^14 whenever part < whole, so 14 quotient bits suffice
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req.start) begin
      busy     <= 1'b1;
      prod     <= ProdW'(req.part) * ProdW'(PctFull);
      den      <= req.whole;
      zero_den <= (req.whole == '0);
      sat      <= (req.part >= req.whole);
      cnt      <= '0;
    end else if (busy) begin
      if (cnt == 4'd0) begin
        rem <= prod[ProdW-1:PctW];
        sh  <= prod[PctW-1:0];
        q   <= '0;
      end else begin
        if (trial >= {1'b0, den}) begin
          rem <= CoordW'(trial - {1'b0, den});
          q   <= {q[PctW-2:0], 1'b1};
        end else begin
          rem <= trial[CoordW-1:0];
          q   <= {q[PctW-2:0], 1'b0};
        end
        sh <= {sh[PctW-2:0], 1'b0};
        if (cnt == 4'(PctW)) begin
          busy <= 1'b0;
        end
      end
      cnt <= cnt + 4'd1;
    end
  end

  assign quot = zero_den ? '0 : (sat ? PctFull : q);

endmodule

/* tb/interval_overlap_classifier_core_test.sv */
module interval_overlap_classifier_core_test;
  import ioc_pkg::*;

  localparam int Depth   = 1024;
  localparam int MaxHits = 64;

  // a kind the block ignores
  localparam logic [KindW-1:0] KIND_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;

  interval_overlap_classifier_core #(.TABLE_DEPTH(Depth), .MAX_HITS(MaxHits)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  always #1 clk = ~clk;

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int        error_count = 0;
  bit        hold_off = 1'b0;
  bit        took = 1'b0;

  // predictor copy of the reference table
  logic [CoordW-1:0] tbl_start[Depth];
  logic [CoordW-1:0] tbl_stop[Depth];
  logic [ClassW-1:0] tbl_class[Depth];
  int                tbl_count = 0;

  function automatic logic [CoordW-1:0] length_of(logic [CoordW-1:0] a,
                                                  logic [CoordW-1:0] b);
    return (b >= a) ? b - a : '0;
  endfunction

  function automatic logic [PctW-1:0] hundredths(logic [CoordW-1:0] part,
                                                 logic [CoordW-1:0] whole);
    longint unsigned p;
    if (whole == 0) return '0;
    p = (longint'(part) * 10000) / longint'(whole);
    return (p > 10000) ? PctFull : p[PctW-1:0];
  endfunction

  function automatic out_item_t make_hit(logic [RelW-1:0] rel, int idx,
                                         logic [CoordW-1:0] ovl,
                                         logic [CoordW-1:0] qlen);
    out_item_t r;
    r = '0;
    r.relation    = rel;
    r.ref_class   = tbl_class[idx];
    r.ref_index   = idx[IndexW-1:0];
    r.ref_start   = tbl_start[idx];
    r.ref_stop    = tbl_stop[idx];
    r.overlap_len = ovl;
    r.query_pct   = hundredths(ovl, qlen);
    r.ref_pct     = hundredths(ovl, length_of(tbl_start[idx], tbl_stop[idx]));
    return r;
  endfunction

  task automatic predict_item(in_item_t it);
    logic [CoordW-1:0] qb, qe, rb, re, qlen, ovl;
    logic [RelW-1:0] rel;
    out_item_t hits[$];
    out_item_t r;
    bit over, hit;
    qb = it.span_start;
    qe = it.span_stop;
    over = 1'b0;
    if (it.kind == KIND_CLEAR) begin
      tbl_count = 0;
      return;
    end
    if (it.kind == KIND_APPEND) begin
      if (tbl_count < Depth) begin
        tbl_start[tbl_count] = qb;
        tbl_stop[tbl_count]  = qe;
        tbl_class[tbl_count] = it.span_class;
        tbl_count++;
      end
      return;
    end
    if (it.kind != KIND_QUERY) return;
    qlen = length_of(qb, qe);
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_start[i] <= qb && qe <= tbl_stop[i]) begin
        r = make_hit(REL_CONTAINED, i, qlen, qlen);
        r.last = 1'b1;
        expected_results = {expected_results, r};
        return;
      end
    end
    for (int i = 0; i < tbl_count; i++) begin
      rb = tbl_start[i];
      re = tbl_stop[i];
      hit = 1'b1;
      if (qb <= rb && re <= qe) begin
        rel = REL_CONTAINS; ovl = length_of(rb, re);
      end else if (qb <= re && re <= qe) begin
        rel = REL_BEGINS; ovl = re - qb;
      end else if (qb <= rb && rb <= qe) begin
        rel = REL_ENDS; ovl = qe - rb;
      end else begin
        hit = 1'b0;
      end
      if (hit) begin
        if (hits.size() >= MaxHits) begin
          over = 1'b1;
          break;
        end
        hits = {hits, make_hit(rel, i, ovl, qlen)};
      end
    end
    if (hits.size() == 0) begin
      r = '0;
      r.relation = REL_NONE;
      r.last = 1'b1;
      hits = {hits, r};
    end else begin
      hits[$].last = 1'b1;
      hits[$].overflow = over;
    end
    foreach (hits[k]) expected_results = {expected_results, hits[k]};
  endtask

  // input acceptance, seen at the rising edge
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      predict_item(pending_items.pop_front());
    end
    took <= !rst && in_valid && !in_stall;
  end

  // driver: bursts and gaps, changes on the falling edge
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (!rst) begin
      // an offered item holds until it has been taken
      if (!in_valid || took) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_valid <= 1'b1;
          in_item <= pending_items[0];
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(12, 1);
            gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(4, 0);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern
  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    if (hold_off) out_stall <= 1'b1;
    else if (stall_phase % 256 < 64) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(3, 0) == 0);
  end

  // long receiver hold-off while the sender keeps offering
  initial begin
    wait (rst == 1'b0);
    repeat (200) @(posedge clk);
    hold_off = 1'b1;
    repeat (3000) @(posedge clk);
    hold_off = 1'b0;
  end

  // monitor
  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: %p", out_item);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_item.relation !== exp_r.relation) begin
          $error("relation exp %0d got %0d", exp_r.relation, out_item.relation); error_count++;
        end
        if (out_item.ref_class !== exp_r.ref_class) begin
          $error("ref_class exp %0d got %0d", exp_r.ref_class, out_item.ref_class); error_count++;
        end
        if (out_item.ref_index !== exp_r.ref_index) begin
          $error("ref_index exp %0d got %0d", exp_r.ref_index, out_item.ref_index); error_count++;
        end
        if (out_item.ref_start !== exp_r.ref_start) begin
          $error("ref_start exp %0d got %0d", exp_r.ref_start, out_item.ref_start); error_count++;
        end
        if (out_item.ref_stop !== exp_r.ref_stop) begin
          $error("ref_stop exp %0d got %0d", exp_r.ref_stop, out_item.ref_stop); error_count++;
        end
        if (out_item.overlap_len !== exp_r.overlap_len) begin
          $error("overlap_len exp %0d got %0d", exp_r.overlap_len, out_item.overlap_len);
          error_count++;
        end
        if (out_item.query_pct !== exp_r.query_pct) begin
          $error("query_pct exp %0d got %0d", exp_r.query_pct, out_item.query_pct); error_count++;
        end
        if (out_item.ref_pct !== exp_r.ref_pct) begin
          $error("ref_pct exp %0d got %0d", exp_r.ref_pct, out_item.ref_pct); error_count++;
        end
        if (out_item.last !== exp_r.last) begin
          $error("last exp %0d got %0d", exp_r.last, out_item.last); error_count++;
        end
        if (out_item.overflow !== exp_r.overflow) begin
          $error("overflow exp %0d got %0d", exp_r.overflow, out_item.overflow); error_count++;
        end
      end
    end
  end

  function automatic in_item_t mk(logic [KindW-1:0] k, logic [CoordW-1:0] a,
                                  logic [CoordW-1:0] b, logic [ClassW-1:0] c);
    in_item_t it;
    it.kind = k; it.span_start = a; it.span_stop = b; it.span_class = c;
    return it;
  endfunction

  task automatic add_item(in_item_t it);
    pending_items = {pending_items, it};
  endtask

  function automatic logic [CoordW-1:0] rnd_coord(int base, int range);
    case ($urandom_range(5, 0))
      0: return CoordW'($urandom);             // full 31-bit width
      1: return '1;
      default: return CoordW'(base + $urandom_range(range, 0));
    endcase
  endfunction

  initial begin
    int base, n, ask;
    logic [CoordW-1:0] a, b;
    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed
    add_item(mk(KIND_QUERY, 10, 20, 0));          // empty table
    add_item(mk(KIND_APPEND, 100, 200, 0));
    add_item(mk(KIND_APPEND, 150, 300, 1));
    add_item(mk(KIND_APPEND, 50, 120, 2));
    add_item(mk(KIND_APPEND, 130, 140, 3));
    add_item(mk(KIND_APPEND, 90, 80, 1));          // inverted
    add_item(mk(KIND_APPEND, 0, '1, 2));
    add_item(mk(KIND_QUERY, 110, 190, 3));         // contained
    add_item(mk(KIND_CLEAR, 0, 0, 0));
    add_item(mk(KIND_APPEND, 100, 200, 0));
    add_item(mk(KIND_APPEND, 150, 300, 1));
    add_item(mk(KIND_APPEND, 50, 120, 2));
    add_item(mk(KIND_APPEND, 130, 140, 3));
    add_item(mk(KIND_APPEND, 90, 80, 1));
    add_item(mk(KIND_APPEND, 5, 5, 0));            // zero length
    add_item(mk(KIND_QUERY, 110, 250, 0));         // mixed relations
    add_item(mk(KIND_QUERY, 85, 85, 0));           // zero-length query
    add_item(mk(KIND_QUERY, 400, 300, 0));         // inverted query
    add_item(mk(KIND_QUERY, '1, '1, 0));
    add_item(mk(KIND_UNUSED, '1, '1, 3));          // unknown kind
    add_item(mk(KIND_QUERY, 0, 0, 0));
    // overflow: 66 small entries inside one query
    add_item(mk(KIND_CLEAR, 0, 0, 0));
    for (int i = 0; i < 66; i++)
      add_item(mk(KIND_APPEND, CoordW'(1000 + i), CoordW'(1001 + i), i[1:0]));
    add_item(mk(KIND_QUERY, 900, 2000, 1));
    // queries that pile up behind a stalled receiver
    for (int i = 0; i < 6; i++)
      add_item(mk(KIND_QUERY, CoordW'(1000 + i), 1100, 0));

    // random: small tables of clustered intervals, mostly queries
    for (int phase = 0; phase < 2; phase++) begin
      base = $urandom_range(1000000, 0);
      add_item(mk(KIND_CLEAR, CoordW'($urandom), CoordW'($urandom), ClassW'($urandom)));
      n = $urandom_range(12, 1);
      for (int i = 0; i < n; i++) begin
        a = rnd_coord(base, 400);
        b = ($urandom_range(7, 0) == 0) ? rnd_coord(base, 400)
                                        : CoordW'(a + $urandom_range(200, 0));
        add_item(mk(KIND_APPEND, a, b, ClassW'($urandom)));
      end
      ask = $urandom_range(10, 4);
      for (int i = 0; i < ask; i++) begin
        a = rnd_coord(base, 500);
        b = ($urandom_range(7, 0) == 0) ? rnd_coord(base, 500)
                                        : CoordW'(a + $urandom_range(300, 0));
        add_item(mk(($urandom_range(15, 0) == 0) ? KIND_UNUSED : KIND_QUERY,
                    a, b, ClassW'($urandom)));
      end
    end

    wait (pending_items.size() == 0 && !in_valid);
    wait (expected_results.size() == 0);
    repeat (200) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
